/* hw/rtl/afms_pkg.sv */
// afms_pkg: constants and the tap coefficient function for the
// mono-to-stereo FIR block. Depends on nothing; used by audio_fir_mono_to_stereo.
package afms_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int TABLE_TAPS      = 11;
    localparam int TABLE_FRAC      = 24;
    localparam int DEF_TAP_COUNT   = 11;
    localparam int DEF_COEF_FRAC   = 24;

    // Low-pass taps as unsigned Q0.24, coef[k] weights the sample k items old
    localparam logic [23:0] COEF_Q24 [TABLE_TAPS] = '{
        24'd3406060, 24'd686933, 24'd735103, 24'd771749, 24'd791067, 24'd799509,
        24'd791067, 24'd771749, 24'd735103, 24'd686933, 24'd3406060
    };

    // Tap k rescaled to frac fractional bits; taps past the table are zero.
    // Narrower formats round to nearest with ties going up.
    function automatic logic [31:0] tap_coef(input int k, input int frac);
        logic [63:0] c;
        int          sh;
        c  = 64'd0;
        sh = 0;
        if (k < TABLE_TAPS) begin
            c = {40'd0, COEF_Q24[k]};
            if (frac >= TABLE_FRAC) begin
                sh = frac - TABLE_FRAC;
                c  = c << sh;
            end else begin
                sh = TABLE_FRAC - frac;
                c  = (c + (64'd1 << (sh - 1))) >> sh;
            end
        end
        return c[31:0];
    endfunction

endpackage

/* hw/rtl/audio_fir_mono_to_stereo.sv */
// audio_fir_mono_to_stereo: top level of the mono-to-stereo FIR path.
// Depends on afms_pkg for the sample width and the coefficient function.
//
// Usage
//   s_valid/s_ready carry one 16-bit mono sample per item (s_sample).
//   m_valid/m_ready carry one stereo pair per item (m_left_sample,
//   m_right_sample), both halves always equal.
//   cfg_wr_en/cfg_wr_data write filter_enable; write it only while idle.
//   With the filter on, each sample enters a TAP_COUNT-tap FIR and the
//   floored sum is returned; with it off the sample is returned as is and
//   the delay line holds.
// Timing
//   Three register stages: input window, tap products, output register.
//   m_valid rises once the item has passed the window, product and output
//   registers; one item is taken every cycle while m_ready keeps up.
//   The latency is set by the split into one stage of constant multiplies
//   feeding one stage of summation.
// Reset and stalls
//   aresetn (synchronous, active low) clears the delay line, the enable
//   and all stage valids. While m_ready is low the items pack up behind
//   the output stage; s_ready falls only once all three stages are full.
module audio_fir_mono_to_stereo #(
    parameter int TAP_COUNT      = afms_pkg::DEF_TAP_COUNT,
    parameter int COEF_FRAC_BITS = afms_pkg::DEF_COEF_FRAC
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [afms_pkg::SAMPLE_W-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [afms_pkg::SAMPLE_W-1:0] m_left_sample,
    output logic [afms_pkg::SAMPLE_W-1:0] m_right_sample
);

    localparam int SW     = afms_pkg::SAMPLE_W;
    localparam int CW     = COEF_FRAC_BITS;
    localparam int PW     = SW + CW;
    localparam int HIST   = TAP_COUNT - 1;
    localparam int ACC_W  = PW + $clog2(TAP_COUNT);

    // Configuration and history
    logic          filter_enable_reg;
    logic [SW-1:0] hist_reg  [HIST];

    // Stage 1: sample window
    logic          v1_reg;
    logic          en1_reg;
    logic [SW-1:0] win_reg   [TAP_COUNT];

    // Stage 2: tap products
    logic          v2_reg;
    logic          en2_reg;
    logic [SW-1:0] pass_reg;
    logic [PW-1:0] prod_reg  [TAP_COUNT];
    logic [PW-1:0] prod_next [TAP_COUNT];

    // Stage 3: result
    logic          v3_reg;
    logic [SW-1:0] out_reg;
    logic [SW-1:0] out_next;
    logic [ACC_W-1:0] acc;

    logic adv1, adv2, adv3, accept;

    // Stage advance: a stage loads when empty or when its successor loads
    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign accept  = s_valid && adv1;

    // Hold the enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            filter_enable_reg <= cfg_wr_data;
        end
    end

    // Advance the delay line only on filtered items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (accept && filter_enable_reg) begin
            hist_reg[0] <= s_sample;
            for (int i = 1; i < HIST; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // Capture the window of newest sample plus history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            en1_reg    <= filter_enable_reg;
            win_reg[0] <= s_sample;
            for (int i = 1; i < TAP_COUNT; i++) begin
                win_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // Multiply each tap by its constant coefficient
    for (genvar g = 0; g < TAP_COUNT; g++) begin : g_tap
        localparam logic [CW-1:0] COEF = CW'(afms_pkg::tap_coef(g, COEF_FRAC_BITS));
        assign prod_next[g] = PW'(win_reg[g]) * PW'(COEF);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            en2_reg  <= en1_reg;
            pass_reg <= win_reg[0];
            for (int i = 0; i < TAP_COUNT; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    // Sum the products, floor and pick filtered or passed sample
    always_comb begin
        acc = '0;
        for (int i = 0; i < TAP_COUNT; i++) begin
            acc = acc + ACC_W'(prod_reg[i]);
        end
        out_next = en2_reg ? acc[CW +: SW] : pass_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3 && v2_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid        = v3_reg;
    assign m_left_sample  = out_reg;
    assign m_right_sample = out_reg;

    // Checks on the stage control and the delay line
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with an empty stage");

    a_hist_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && filter_enable_reg) |=> $stable(hist_reg[0]))
        else $error("delay line moved without a filtered item");

    a_hist_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && filter_enable_reg) |=> (hist_reg[0] == $past(s_sample)))
        else $error("delay line missed the new sample");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("stalled result changed");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for audio_fir_mono_to_stereo, filter on and off.
// Depends on afms_pkg (sample width) and the block's RTL; needs nothing else.
module tb;

    localparam int SW          = afms_pkg::SAMPLE_W;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 230;
    localparam int DRAIN_WAIT  = 8;

    // Tracks filter_enable and the delay line, and holds the expected pairs
    class fir_pair_tracker;
        localparam int NTAPS    = 11;
        localparam int HIST_LEN = NTAPS - 1;
        localparam int FRAC     = 24;

        logic [23:0]   taps [NTAPS];
        logic [SW-1:0] history [HIST_LEN];
        bit            enabled;
        logic [SW-1:0] expected_out [$];
        int            errors;

        function new();
            taps = '{24'd3406060, 24'd686933, 24'd735103, 24'd771749, 24'd791067,
                     24'd799509, 24'd791067, 24'd771749, 24'd735103, 24'd686933,
                     24'd3406060};
            foreach (history[i]) history[i] = '0;
            enabled = 1'b0;
            errors  = 0;
        endfunction

        function void set_enable(bit en);
            enabled = en;
        endfunction

        // Floored FIR sum of the new sample and the delay line
        function logic [SW-1:0] filtered_value(logic [SW-1:0] x);
            logic [63:0] acc;
            acc = 64'(taps[0]) * 64'(x);
            for (int k = 1; k < NTAPS; k++)
                acc += 64'(taps[k]) * 64'(history[k-1]);
            return SW'(acc >> FRAC);
        endfunction

        // Predict the pair for an accepted item and advance the delay line
        function void note_sample(logic [SW-1:0] x);
            if (enabled) begin
                expected_out.push_back(filtered_value(x));
                for (int k = HIST_LEN - 1; k > 0; k--)
                    history[k] = history[k-1];
                history[0] = x;
            end else begin
                expected_out.push_back(x);
            end
        endfunction

        // Compare an accepted pair with the oldest expectation
        function void check_pair(logic [SW-1:0] left, logic [SW-1:0] right);
            logic [SW-1:0] want;
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected result, expected none, got left %0d right %0d",
                         $time, left, right);
                errors++;
                return;
            end
            want = expected_out.pop_front();
            if (left !== want) begin
                $display("%0t: left_sample expected %0d got %0d", $time, want, left);
                errors++;
            end
            if (right !== want) begin
                $display("%0t: right_sample expected %0d got %0d", $time, want, right);
                errors++;
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic          cfg_wr_data;
    logic          s_valid;
    logic          s_ready;
    logic [SW-1:0] s_sample;
    logic          m_valid;
    logic          m_ready;
    logic [SW-1:0] m_left_sample;
    logic [SW-1:0] m_right_sample;

    fir_pair_tracker pairs = new();

    int cycle_count = 0;
    int stall_left  = 0;
    bit ready_steady = 1'b0;

    audio_fir_mono_to_stereo i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_sample  (m_left_sample),
        .m_right_sample (m_right_sample)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watch both channels: note each accepted item first, then check results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                pairs.note_sample(s_sample);
            if (m_valid && m_ready)
                pairs.check_pair(m_left_sample, m_right_sample);
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pairs.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side back-pressure: steady ready in some phases, else mostly ready, short stalls, the odd long one
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (ready_steady) begin
            m_ready = 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                14, 15, 16, 17: begin
                    m_ready    = 1'b0;
                    stall_left = $urandom_range(0, 2);
                end
                18, 19: begin
                    m_ready    = 1'b0;
                    stall_left = $urandom_range(4, 40);
                end
                default: m_ready = 1'b1;
            endcase
        end
    end

    function automatic int pick_gap();
        case ($urandom_range(0, 19))
            12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
            18, 19:                 return $urandom_range(4, 30);
            default:                return 0;
        endcase
    endfunction

    // Bias towards the extremes, single bits and near-full scale
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SW'($urandom_range(0, 15));
            3:       return SW'(16'hFFFF - $urandom_range(0, 15));
            4:       return SW'(1) << $urandom_range(0, SW - 1);
            default: return SW'($urandom);
        endcase
    endfunction

    // Offer one item; entered and left at a falling edge
    task automatic send_sample(input logic [SW-1:0] value, input bit gaps);
        int idle;
        idle = gaps ? pick_gap() : 0;
        if (idle > 0) begin
            s_valid = 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_sample = value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Write filter_enable once the pipeline has drained
    task automatic write_enable(input bit en);
        s_valid = 1'b0;
        while (pairs.pending() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_wr_data = en;
        cfg_wr_en   = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        pairs.set_enable(en);
    endtask

    initial begin
        logic [SW-1:0] bypass_set [6];
        logic [SW-1:0] filter_set [4];
        bit            gaps;

        bypass_set = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555};
        filter_set = '{16'h5555, 16'hAAAA, 16'h0001, 16'h8000};

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid     = 1'b0;
        s_sample    = '0;
        m_ready     = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Pass-through at the field extremes and alternating bits
        write_enable(1'b0);
        foreach (bypass_set[i]) send_sample(bypass_set[i], 1'b1);

        // Fill the delay line with full scale, then step away from it
        write_enable(1'b1);
        repeat (11) send_sample(16'hFFFF, 1'b1);
        foreach (filter_set[i]) send_sample(filter_set[i], 1'b1);

        // Random phases, alternating filter on and off; the line holds while off
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_enable(p % 2 == 0 ? 1'b0 : 1'b1);
            gaps = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    gaps         = $urandom_range(0, 3) != 0;
                    ready_steady = $urandom_range(0, 3) == 0;
                end
                send_sample(pick_sample(), gaps);
            end
        end

        // Drain and let the pipeline settle
        s_valid      = 1'b0;
        ready_steady = 1'b0;
        while (pairs.pending() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (pairs.errors == 0 && pairs.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* audio_fir_mono_to_stereo.f */
hw/rtl/afms_pkg.sv
hw/rtl/audio_fir_mono_to_stereo.sv
sim/tb.sv
